// ===== rtl/brb_pkg.sv =====
// Shared constants and types for the byte ring buffer.
// Used by brb_front, brb_back, byte_ring_buffer and its testbench; depends on nothing.
package brb_pkg;

    localparam int CMD_W         = 3;
    localparam int DATA_W        = 8;
    localparam int CNT_W         = 6;
    localparam int CAP_W         = 9;
    localparam int DEPTH_DEF     = 256;
    localparam int MAX_COUNT_DEF = 32;

    // command codes as seen on the input and in the queue
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COPY      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SKIP      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP       = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE     = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  amt;
    } brb_op_t;

endpackage

// ===== rtl/brb_front.sv =====
// Front end: accepts command beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on brb_pkg.
module brb_front #(
    parameter int MAX_COUNT = brb_pkg::MAX_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brb_pkg::CMD_W-1:0]   command,
    input  logic [brb_pkg::DATA_W-1:0]  data_in,
    input  logic [brb_pkg::CNT_W-1:0]   amount,
    output logic                        q_valid,
    output brb_pkg::brb_op_t            q_op,
    input  logic                        q_pop
);
    import brb_pkg::*;

    brb_op_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    brb_op_t    dec;

    // classify: unknown codes become no-ops, amount saturates
    always_comb
    begin
        dec.data = data_in;
        if ({1'b0, amount} > (CNT_W+1)'(MAX_COUNT))
            dec.amt = CNT_W'(MAX_COUNT);
        else
            dec.amt = amount;
        case (command)
            CMD_WRITE, CMD_OVERWRITE, CMD_READ, CMD_COPY, CMD_SKIP, CMD_ERASE:
                dec.op = command;
            default:
                dec.op = CMD_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid))
            count_next = count_reg + 2'd1;
        else if (!push && q_pop && q_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

// ===== rtl/brb_back.sv =====
// Back end: owns storage, positions, fill and capacity; carries out queued
// commands and drives the output register. Depends on brb_pkg.
module brb_back #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        capacity_we,
    input  logic [brb_pkg::CAP_W-1:0]   capacity,
    input  logic                        q_valid,
    input  brb_pkg::brb_op_t            q_op,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [brb_pkg::DATA_W-1:0]  data_out,
    output logic                        has_data,
    output logic [brb_pkg::CNT_W-1:0]   done_count,
    output logic [brb_pkg::CAP_W-1:0]   fill_level,
    output logic                        last
);
    import brb_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W   = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
    localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic              state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CAP_W-1:0]  held_reg, held_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              is_read_reg, is_read_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_has_reg, out_has_next;
    logic [CNT_W-1:0]  out_done_reg, out_done_next;
    logic [CAP_W-1:0]  out_fill_reg, out_fill_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              out_free;

    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;

    logic [CNT_W-1:0]  n_avail;
    logic [POS_W-1:0]  cap_x, wp_x, rp_x, pos_x, n_x;
    logic [POS_W-1:0]  wp_inc, rp_inc, pos_inc, rp_sum;
    logic [POS_W-1:0]  wp_adv, rp_adv, pos_adv, rp_skip, wp_back;
    logic [POS_W-1:0]  cap_in_x;
    logic [CAP_W-1:0]  cap_clamped;

    assign out_free = !out_valid_reg || !out_stall;

    // bytes actually available to a multi-byte command
    assign n_avail = ({{(CAP_W-CNT_W){1'b0}}, q_op.amt} < held_reg)
                   ? q_op.amt : held_reg[CNT_W-1:0];

    assign cap_x  = POS_W'(cap_reg);
    assign wp_x   = POS_W'(wp_reg);
    assign rp_x   = POS_W'(rp_reg);
    assign pos_x  = POS_W'(pos_reg);
    assign n_x    = POS_W'(n_avail);

    // wrap at capacity, not at the storage depth
    assign wp_inc  = wp_x + POS_W'(1);
    assign rp_inc  = rp_x + POS_W'(1);
    assign pos_inc = pos_x + POS_W'(1);
    assign wp_adv  = (wp_inc >= cap_x) ? '0 : wp_inc;
    assign rp_adv  = (rp_inc >= cap_x) ? '0 : rp_inc;
    assign pos_adv = (pos_inc >= cap_x) ? '0 : pos_inc;
    assign rp_sum  = rp_x + n_x;
    assign rp_skip = (rp_sum >= cap_x) ? rp_sum - cap_x : rp_sum;
    assign wp_back = (wp_x >= n_x) ? wp_x - n_x : wp_x + cap_x - n_x;

    assign cap_in_x = POS_W'(capacity);
    always_comb
    begin
        if (capacity == '0)
            cap_clamped = CAP_W'(1);
        else if (cap_in_x > POS_W'(DEPTH))
            cap_clamped = CAP_W'(DEPTH);
        else
            cap_clamped = capacity;
    end

    always_comb
    begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        held_next     = held_reg;
        pos_next      = pos_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        is_read_next  = is_read_reg;
        fill_next     = fill_reg;
        q_pop         = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rp_reg;
        out_load      = 1'b0;
        out_data_next = '0;
        out_has_next  = 1'b0;
        out_done_next = '0;
        out_fill_next = held_reg;
        out_last_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    case (q_op.op)
                        CMD_WRITE:
                        begin
                            if (held_reg < cap_reg)
                            begin
                                wr_en         = 1'b1;
                                wp_next       = PTR_W'(wp_adv);
                                held_next     = held_reg + CAP_W'(1);
                                out_done_next = CNT_W'(1);
                            end
                        end
                        CMD_OVERWRITE:
                        begin
                            wr_en         = 1'b1;
                            wp_next       = PTR_W'(wp_adv);
                            out_done_next = CNT_W'(1);
                            // full: drop the oldest byte, fill stays
                            if (held_reg >= cap_reg)
                                rp_next = PTR_W'(rp_adv);
                            else
                                held_next = held_reg + CAP_W'(1);
                        end
                        CMD_READ, CMD_COPY:
                        begin
                            if (n_avail != '0)
                            begin
                                out_load     = 1'b0;
                                rd_en        = 1'b1;
                                rd_addr      = rp_reg;
                                pos_next     = rp_reg;
                                n_next       = n_avail;
                                cnt_next     = '0;
                                is_read_next = (q_op.op == CMD_READ);
                                fill_next    = (q_op.op == CMD_READ)
                                             ? held_reg - CAP_W'(n_avail) : held_reg;
                                state_next   = ST_READ;
                            end
                        end
                        CMD_SKIP:
                        begin
                            rp_next       = PTR_W'(rp_skip);
                            held_next     = held_reg - CAP_W'(n_avail);
                            out_done_next = n_avail;
                        end
                        CMD_ERASE:
                        begin
                            wp_next       = PTR_W'(wp_back);
                            held_next     = held_reg - CAP_W'(n_avail);
                            out_done_next = n_avail;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_fill_next = held_next;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_data_next = rdata_reg;
                    out_has_next  = 1'b1;
                    out_done_next = cnt_reg + CNT_W'(1);
                    out_fill_next = fill_reg;
                    out_last_next = (cnt_reg + CNT_W'(1) == n_reg);
                    cnt_next      = cnt_reg + CNT_W'(1);
                    pos_next      = PTR_W'(pos_adv);
                    if (out_last_next)
                    begin
                        if (is_read_reg)
                        begin
                            rp_next   = PTR_W'(pos_adv);
                            held_next = fill_reg;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next byte while this one goes out
                        rd_en   = 1'b1;
                        rd_addr = PTR_W'(pos_adv);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (capacity_we)
        begin
            cap_next  = cap_clamped;
            wp_next   = '0;
            rp_next   = '0;
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(CAP_RST);
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            is_read_reg   <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            held_reg    <= held_next;
            pos_reg     <= pos_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            is_read_reg <= is_read_next;
            fill_reg    <= fill_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_has_reg  <= out_has_next;
            out_done_reg <= out_done_next;
            out_fill_reg <= out_fill_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= q_op.data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = out_data_reg;
    assign has_data   = out_has_reg;
    assign done_count = out_done_reg;
    assign fill_level = out_fill_reg;
    assign last       = out_last_reg;

endmodule

// ===== rtl/byte_ring_buffer.sv =====
// Byte ring buffer top level: front end and queue, back end with storage.
// Each command beat passes the front queue, its result the output register;
// a read or copy reads storage through a registered port, then gives one
// byte per cycle unless the output stalls. The back end takes one single-result
// command per cycle unless stalled, and none until a read or copy ends.
// Reset clears positions, fill and queue and sets capacity to min(256, DEPTH);
// storage is not cleared. Depends on brb_pkg, brb_front and brb_back.
module byte_ring_buffer #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEF,
    parameter int MAX_COUNT = brb_pkg::MAX_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        capacity_we,
    input  logic [brb_pkg::CAP_W-1:0]   capacity,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brb_pkg::CMD_W-1:0]   command,
    input  logic [brb_pkg::DATA_W-1:0]  data_in,
    input  logic [brb_pkg::CNT_W-1:0]   amount,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [brb_pkg::DATA_W-1:0]  data_out,
    output logic                        has_data,
    output logic [brb_pkg::CNT_W-1:0]   done_count,
    output logic [brb_pkg::CAP_W-1:0]   fill_level,
    output logic                        last
);
    import brb_pkg::*;

    logic    q_valid;
    logic    q_pop;
    brb_op_t q_op;

    brb_front #(
        .MAX_COUNT (MAX_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .data_in  (data_in),
        .amount   (amount),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop)
    );

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .has_data    (has_data),
        .done_count  (done_count),
        .fill_level  (fill_level),
        .last        (last)
    );

    // a delivered byte always counts itself
    a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_data |-> done_count != '0)
        else $error("delivered byte with zero count");

    // a beat without data is always the only, hence final, result
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> last)
        else $error("result without data not marked last");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(fill_level) <= DEPTH)
        else $error("fill level beyond storage depth");

    // pop only while the queue holds a beat
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ===== tb/sv/byte_ring_buffer_tb.sv =====
// Self-checking testbench for byte_ring_buffer: directed and random command beats,
// an in-house ring model predicting every result beat, random stalls on both sides.
// Depends on brb_pkg and the byte_ring_buffer RTL.
module byte_ring_buffer_tb;

    import brb_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              has;
        logic [CNT_W-1:0]  done;
        logic [CAP_W-1:0]  fill;
        logic              fin;
    } reply_t;

    localparam int HOLD_CYCLES = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               capacity_we = 1'b0;
    logic [CAP_W-1:0]   capacity = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command = CMD_WRITE;
    logic [DATA_W-1:0]  data_in = '0;
    logic [CNT_W-1:0]   amount = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DATA_W-1:0]  data_out;
    logic               has_data;
    logic [CNT_W-1:0]   done_count;
    logic [CAP_W-1:0]   fill_level;
    logic               last;

    // ring model state
    logic [DATA_W-1:0]  m_mem [0:DEPTH_DEF-1];
    logic [7:0]         m_wr = '0;
    logic [7:0]         m_rd = '0;
    logic [CAP_W-1:0]   m_held = '0;
    logic [CAP_W-1:0]   m_cap = CAP_W'(DEPTH_DEF);

    brb_op_t            pending_cmds [$];
    reply_t             awaited_replies [$];
    int                 mismatches = 0;
    int                 in_gap = 0;
    int                 out_gap = 0;
    int                 hold_left = 0;
    bit                 hold_used = 1'b0;
    bit                 hold_armed = 1'b0;
    bit                 calm = 1'b0;

    byte_ring_buffer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_in     (data_in),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .has_data    (has_data),
        .done_count  (done_count),
        .fill_level  (fill_level),
        .last        (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] step_fwd(logic [7:0] p);
        return ({1'b0, p} + 9'd1 >= m_cap) ? 8'd0 : p + 8'd1;
    endfunction

    function automatic logic [7:0] step_back(logic [7:0] p);
        if (p == 8'd0 || {1'b0, p} > m_cap)
            return 8'(m_cap - 9'd1);
        return p - 8'd1;
    endfunction

    // Advance the ring model by one command beat and queue the result beats it gives.
    task automatic apply_command(input brb_op_t c);
        logic [DATA_W-1:0] got_bytes [0:MAX_COUNT_DEF-1];
        logic [7:0]        pos;
        int                amt;
        int                done;
        begin
            amt = (c.amt > MAX_COUNT_DEF) ? MAX_COUNT_DEF : int'(c.amt);
            done = 0;
            case (c.op)
                CMD_WRITE:
                    if (m_held < m_cap)
                    begin
                        m_mem[m_wr] = c.data;
                        m_wr = step_fwd(m_wr);
                        m_held = m_held + CAP_W'(1);
                        done = 1;
                    end
                CMD_OVERWRITE:
                begin
                    // full: drop the oldest byte first
                    if (m_held >= m_cap)
                    begin
                        m_rd = step_fwd(m_rd);
                        m_held = m_held - CAP_W'(1);
                    end
                    m_mem[m_wr] = c.data;
                    m_wr = step_fwd(m_wr);
                    m_held = m_held + CAP_W'(1);
                    done = 1;
                end
                CMD_READ, CMD_COPY:
                begin
                    pos = m_rd;
                    while (done < amt && done < m_held)
                    begin
                        got_bytes[done] = m_mem[pos];
                        pos = step_fwd(pos);
                        done++;
                    end
                    if (c.op == CMD_READ)
                    begin
                        m_rd = pos;
                        m_held = m_held - CAP_W'(done);
                    end
                end
                CMD_SKIP:
                    while (done < amt && m_held > 0)
                    begin
                        m_rd = step_fwd(m_rd);
                        m_held = m_held - CAP_W'(1);
                        done++;
                    end
                CMD_ERASE:
                    while (done < amt && m_held > 0)
                    begin
                        m_wr = step_back(m_wr);
                        m_held = m_held - CAP_W'(1);
                        done++;
                    end
                default: ;
            endcase
            if ((c.op == CMD_READ || c.op == CMD_COPY) && done != 0)
            begin
                for (int k = 0; k < done; k++)
                    awaited_replies.push_back({got_bytes[k], 1'b1, CNT_W'(k + 1), m_held,
                                               (k + 1 == done)});
            end
            else
                awaited_replies.push_back({8'd0, 1'b0, CNT_W'(done), m_held, 1'b1});
        end
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] d,
                             input logic [CNT_W-1:0] n);
        pending_cmds.push_back({op, d, n});
    endtask

    function automatic brb_op_t random_command();
        brb_op_t c;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 35)
            c.op = CMD_WRITE;
        else if (r < 50)
            c.op = CMD_OVERWRITE;
        else if (r < 68)
            c.op = CMD_READ;
        else if (r < 78)
            c.op = CMD_COPY;
        else if (r < 87)
            c.op = CMD_SKIP;
        else if (r < 96)
            c.op = CMD_ERASE;
        else
            c.op = ($urandom_range(0, 1) == 0) ? CMD_NOP : CMD_SPARE;
        c.data = DATA_W'($urandom_range(0, 255));
        c.amt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 63))
                                            : CNT_W'($urandom_range(0, 6));
        return c;
    endfunction

    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || in_valid || awaited_replies.size() != 0)
            @(negedge clk);
    endtask

    // Only called with the block quiet; the buffer empties on every write.
    task automatic set_capacity(input logic [CAP_W-1:0] v);
        wait_quiet();
        repeat (6) @(posedge clk);
        capacity_we <= 1'b1;
        capacity <= v;
        @(posedge clk);
        capacity_we <= 1'b0;
        if (v == 0)
            m_cap = CAP_W'(1);
        else if (v > DEPTH_DEF)
            m_cap = CAP_W'(DEPTH_DEF);
        else
            m_cap = v;
        m_wr = '0;
        m_rd = '0;
        m_held = '0;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_cmds.push_back(random_command());
    endtask

    // Sender: present one command beat, hold it while stalled.
    always @(posedge clk or negedge rst_n)
    begin : in_side
        brb_op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_WRITE;
            data_in <= '0;
            amount <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_command({command, data_in, amount});
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && pending_cmds.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    in_gap <= $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    nxt = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    command <= nxt.op;
                    data_in <= nxt.data;
                    amount <= nxt.amt;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, started once the pressure phase arms it.
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_armed && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check each accepted result beat against the oldest awaited one.
    always @(posedge clk or negedge rst_n)
    begin : out_side
        reply_t got;
        reply_t exp;
        logic   stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {data_out, has_data, done_count, fill_level, last};
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: data %0d has %0d done %0d fill %0d last %0d",
                                 got.data, got.has, got.done, got.fill, got.fin);
                end
                else
                begin
                    exp = awaited_replies.pop_front();
                    if (got.data !== exp.data || got.has !== exp.has || got.done !== exp.done
                        || got.fill !== exp.fill || got.fin !== exp.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected data %0d has %0d done %0d fill %0d ",
                                      "last %0d, got data %0d has %0d done %0d fill %0d last %0d"},
                                     exp.data, exp.has, exp.done, exp.fill, exp.fin,
                                     got.data, got.has, got.done, got.fill, got.fin);
                    end
                end
            end
            if (out_gap != 0)
            begin
                out_gap <= out_gap - 1;
                stall_next = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_gap <= $urandom_range(0, 7);
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            out_stall <= stall_next || (hold_left != 0);
        end
    end

    initial
    begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty buffer, byte extremes, zero and saturated amounts, unknown commands
        queue_cmd(CMD_READ, 8'h00, 6'd5);
        queue_cmd(CMD_COPY, 8'h00, 6'd1);
        queue_cmd(CMD_SKIP, 8'h00, 6'd3);
        queue_cmd(CMD_ERASE, 8'h00, 6'd2);
        queue_cmd(CMD_WRITE, 8'h00, 6'd0);
        queue_cmd(CMD_WRITE, 8'hFF, 6'd0);
        queue_cmd(CMD_OVERWRITE, 8'hA5, 6'd0);
        queue_cmd(CMD_COPY, 8'h00, 6'd0);
        queue_cmd(CMD_COPY, 8'h00, 6'd63);
        queue_cmd(CMD_ERASE, 8'h00, 6'd1);
        queue_cmd(CMD_SPARE, 8'hFF, 6'd63);
        queue_cmd(CMD_NOP, 8'h00, 6'd0);
        queue_cmd(CMD_READ, 8'h00, 6'd33);

        // small ring: refuse on full, overwrite drops oldest, wrap both ways
        set_capacity(9'd3);
        queue_cmd(CMD_WRITE, 8'h11, 6'd0);
        queue_cmd(CMD_WRITE, 8'h22, 6'd0);
        queue_cmd(CMD_WRITE, 8'h33, 6'd0);
        queue_cmd(CMD_WRITE, 8'h44, 6'd0);
        queue_cmd(CMD_OVERWRITE, 8'h55, 6'd0);
        queue_cmd(CMD_ERASE, 8'h00, 6'd1);
        queue_cmd(CMD_COPY, 8'h00, 6'd32);
        queue_cmd(CMD_SKIP, 8'h00, 6'd1);
        queue_cmd(CMD_READ, 8'h00, 6'd2);

        // zero capacity acts as one slot
        set_capacity(9'd0);
        queue_cmd(CMD_WRITE, 8'h80, 6'd0);
        queue_cmd(CMD_OVERWRITE, 8'h7F, 6'd0);
        queue_cmd(CMD_READ, 8'h00, 6'd1);

        // oversize capacity saturates
        set_capacity(9'd511);
        queue_random(15);
        set_capacity(9'd2);
        queue_random(12);

        // hold the receiver off long enough for the block to back up
        set_capacity(9'd64);
        hold_armed = 1'b1;
        queue_random(35);

        set_capacity(9'd17);
        queue_random(12);

        wait_quiet();
        calm = 1'b1;
        set_capacity(9'd256);
        queue_random(15);

        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== byte_ring_buffer.f =====
rtl/brb_pkg.sv
rtl/brb_front.sv
rtl/brb_back.sv
rtl/byte_ring_buffer.sv
tb/sv/byte_ring_buffer_tb.sv
